/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Immediate-implication and next-cycle-implication property checks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define SRR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SRR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/srr_pkg.sv */
// ---------------------------------------------------------------------------
// srr_pkg
// Shared constants, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srr_pkg;

	localparam int WINDOW      = 4;
	localparam int MAX_FRAMES  = 1024;
	localparam int MAX_RESULTS = 4;

	localparam int TOT_W  = 11;
	localparam int FN_W   = 10;
	localparam int KIND_W = 2;

	localparam int WIN_IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int OFF_W     = $clog2(WINDOW + 1);
	localparam int CNT_W     = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		ST_EMPTY,
		ST_RECEIVED,
		ST_ACKED
	} fstat_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ACCEPT,
		KIND_REJECT,
		KIND_ACK,
		KIND_NOACK
	} kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SLIDE,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic arrival;
		logic scan_start;
		logic ack;
		logic skip;
		logic slide;
		logic flush;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic scan_end;
		logic slot_recv;
		logic k_zero;
		logic slide_more;
		logic pend_v;
	} dp_sts_t;

endpackage

`default_nettype wire

/* src/srr_ctrl.sv */
// ---------------------------------------------------------------------------
// srr_ctrl
// Sequencer for frame arrivals and acknowledgement scans.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srr_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             req_type,
	output logic                  in_stall,
	input  wire srr_pkg::dp_sts_t sts,
	output srr_pkg::dp_cmd_t      cmd
);
	import srr_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign take = (state_q == S_IDLE) && in_valid && sts.out_free;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (take && req_type) state_nxt = S_SCAN;
			end
			S_SCAN: begin
				if (sts.scan_end) begin
					state_nxt = S_FLUSH;
				end else if (sts.slot_recv && (!sts.pend_v || sts.out_free) && sts.k_zero) begin
					// head of window acknowledged: slide the base before going on
					state_nxt = S_SLIDE;
				end
			end
			S_SLIDE: begin
				if (!sts.slide_more) state_nxt = S_SCAN;
			end
			S_FLUSH: begin
				if (sts.out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall       = !sts.out_free;
				cmd.arrival    = take && !req_type;
				cmd.scan_start = take && req_type;
			end
			S_SCAN: begin
				// hold while an earlier acknowledgement waits for the output register
				cmd.ack  = !sts.scan_end && sts.slot_recv && (!sts.pend_v || sts.out_free);
				cmd.skip = !sts.scan_end && !sts.slot_recv;
			end
			S_SLIDE: begin
				cmd.slide = sts.slide_more;
			end
			S_FLUSH: begin
				cmd.flush = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* src/srr_dp.sv */
// ---------------------------------------------------------------------------
// srr_dp
// Window status registers, base pointer, scan counters and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srr_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire srr_pkg::dp_cmd_t             cmd,
	output srr_pkg::dp_sts_t                  sts,
	input  wire logic [srr_pkg::FN_W-1:0]     frame_number,
	input  wire logic                         cfg_wr_en,
	input  wire logic [srr_pkg::TOT_W-1:0]    cfg_wr_data,
	input  wire logic                         out_stall,
	output logic                              out_valid,
	output logic [srr_pkg::KIND_W-1:0]        result_kind,
	output logic [srr_pkg::FN_W-1:0]          ack_number,
	output logic [srr_pkg::TOT_W-1:0]         window_base,
	output logic                              all_done,
	output logic                              last
);
	import srr_pkg::*;

	// status of frames base .. base+WINDOW-1; frames above the window are always empty
	fstat_t               win_q [WINDOW];
	logic [TOT_W-1:0]     tot_q;
	logic [TOT_W-1:0]     base_q;
	logic [OFF_W-1:0]     k_q;
	logic [CNT_W-1:0]     n_q;
	logic                 pend_v_q;
	logic [FN_W-1:0]      pend_q;

	logic                 out_v_q;
	logic [KIND_W-1:0]    kind_q;
	logic [FN_W-1:0]      num_q;
	logic [TOT_W-1:0]     obase_q;
	logic                 done_q;
	logic                 last_q;

	logic [TOT_W-1:0]     tot_eff;
	logic                 done;
	logic [TOT_W-1:0]     f_ext;
	logic [TOT_W-1:0]     diff;
	logic                 in_win;
	logic [WIN_IDX_W-1:0] widx;
	logic [WIN_IDX_W-1:0] kidx;
	logic [TOT_W:0]       pos;
	logic                 out_load;

	assign tot_eff = (tot_q > TOT_W'(MAX_FRAMES)) ? TOT_W'(MAX_FRAMES) : tot_q;
	assign done    = base_q >= tot_eff;

	assign f_ext  = {1'b0, frame_number};
	assign diff   = f_ext - base_q;
	assign in_win = (f_ext >= base_q) && (diff < TOT_W'(WINDOW)) && (f_ext < tot_eff);
	assign widx   = diff[WIN_IDX_W-1:0];

	assign kidx = k_q[WIN_IDX_W-1:0];
	assign pos  = {1'b0, base_q} + (TOT_W+1)'(k_q);

	assign sts.scan_end   = (n_q == CNT_W'(MAX_RESULTS)) || (k_q >= OFF_W'(WINDOW))
	                        || (pos >= {1'b0, tot_eff});
	assign sts.slot_recv  = (win_q[kidx] == ST_RECEIVED);
	assign sts.k_zero     = (k_q == '0);
	assign sts.slide_more = (base_q < tot_eff) && (win_q[0] == ST_ACKED);
	assign sts.pend_v     = pend_v_q;
	assign sts.out_free   = !out_v_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < WINDOW; j++) win_q[j] <= ST_EMPTY;
			base_q <= '0;
		end else if (cmd.arrival && in_win) begin
			win_q[widx] <= ST_RECEIVED;
		end else if (cmd.ack) begin
			win_q[kidx] <= ST_ACKED;
		end else if (cmd.slide) begin
			// advance the window by one frame; the new top frame enters as empty
			for (int j = 0; j < WINDOW - 1; j++) win_q[j] <= win_q[j+1];
			win_q[WINDOW-1] <= ST_EMPTY;
			base_q          <= base_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q <= TOT_W'(10);
		end else if (cfg_wr_en) begin
			tot_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			n_q      <= '0;
			pend_v_q <= 1'b0;
		end else if (cmd.scan_start) begin
			k_q      <= '0;
			n_q      <= '0;
			pend_v_q <= 1'b0;
		end else if (cmd.skip) begin
			k_q <= k_q + 1'b1;
		end else if (cmd.ack) begin
			// an ack at the head keeps k at zero: the slide moves the window under it
			if (k_q != '0) k_q <= k_q + 1'b1;
			n_q      <= n_q + 1'b1;
			pend_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ack) pend_q <= pos[FN_W-1:0];
	end

	assign out_load = cmd.arrival || (cmd.ack && pend_v_q) || cmd.flush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			obase_q <= base_q;
			done_q  <= done;
			if (cmd.arrival) begin
				kind_q <= in_win ? KIND_ACCEPT : KIND_REJECT;
				num_q  <= frame_number;
				last_q <= 1'b1;
			end else if (cmd.ack) begin
				kind_q <= KIND_ACK;
				num_q  <= pend_q;
				last_q <= 1'b0;
			end else begin
				kind_q <= pend_v_q ? KIND_ACK : KIND_NOACK;
				num_q  <= pend_v_q ? pend_q : '0;
				last_q <= 1'b1;
			end
		end
	end

	assign out_valid   = out_v_q;
	assign result_kind = kind_q;
	assign ack_number  = num_q;
	assign window_base = obase_q;
	assign all_done    = done_q;
	assign last        = last_q;

endmodule

`default_nettype wire

/* src/selective_repeat_receiver.sv */
// ---------------------------------------------------------------------------
// selective_repeat_receiver
// Receiver side of a selective-repeat sliding window protocol.
// ---------------------------------------------------------------------------
// A frame-arrival word gives one result. An acknowledgement scan word is
// accepted, visits the window positions in order, slides the base over each
// acknowledged frame at the head of the window, and then delivers its final
// result; when the transfer is done it goes straight to that result. A stalled
// output holds back the acceptance of either word and the delivery of results.
// Only the WINDOW frames from the base upward are held in registers; frames above
// the window are known to be empty, so no clearing pass follows reset. The last
// result of each scan word is held back one slot until the scan knows whether
// another acknowledgement follows.
`timescale 1ns / 1ps
`default_nettype none

module selective_repeat_receiver (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic [srr_pkg::TOT_W-1:0]    cfg_wr_data,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         req_type,
	input  wire logic [srr_pkg::FN_W-1:0]     frame_number,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [srr_pkg::KIND_W-1:0]        result_kind,
	output logic [srr_pkg::FN_W-1:0]          ack_number,
	output logic [srr_pkg::TOT_W-1:0]         window_base,
	output logic                              all_done,
	output logic                              last
);
	import srr_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	srr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	srr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.frame_number (frame_number),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.result_kind  (result_kind),
		.ack_number   (ack_number),
		.window_base  (window_base),
		.all_done     (all_done),
		.last         (last)
	);

endmodule

`default_nettype wire

/* src/srr_checker.sv */
// ---------------------------------------------------------------------------
// srr_checker
// Port-level checks on the receiver's result stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module srr_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire logic [srr_pkg::KIND_W-1:0]   result_kind,
	input wire logic [srr_pkg::FN_W-1:0]     ack_number,
	input wire logic [srr_pkg::TOT_W-1:0]    window_base,
	input wire logic                         all_done,
	input wire logic                         last
);
	import srr_pkg::*;

	`SRR_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(result_kind) && $stable(ack_number) && $stable(window_base) && $stable(all_done) && $stable(last), "stalled result word changed")
	`SRR_ASSERT_IMP(a_noack_single, clk, arst_n, out_valid && result_kind == KIND_NOACK, last && ack_number == '0, "empty scan result not single or number not zero")
	`SRR_ASSERT_IMP(a_accept_in_window, clk, arst_n, out_valid && result_kind == KIND_ACCEPT, !all_done && TOT_W'(ack_number) >= window_base && int'(ack_number) < int'(window_base) + WINDOW, "accepted frame outside window")
	`SRR_ASSERT_IMP(a_ack_bound, clk, arst_n, out_valid && result_kind == KIND_ACK, int'(ack_number) < int'(window_base) + WINDOW, "acknowledged frame above window")
	`SRR_ASSERT_IMP(a_arrival_single, clk, arst_n, out_valid && (result_kind == KIND_ACCEPT || result_kind == KIND_REJECT), last, "arrival result not marked last")

endmodule

bind selective_repeat_receiver srr_checker u_srr_checker (.*);

`default_nettype wire
